// File: src/lpe_pkg.sv
// shared constants, types and weight table for the line position estimator
package lpe_pkg;

    localparam int SENSORS      = 7;
    localparam int ADC_BITS_DEF = 10;
    localparam int IDX_W        = 3;
    localparam int SCALE_W      = 7;      // scaled value 0..100
    localparam int SCALE_FULL   = 100;
    localparam int POS_LIMIT    = 700;
    localparam int POS_W        = 11;
    localparam int WSUM_W       = 14;     // +/-6600
    localparam int TOTAL_W      = 10;     // 0..700
    localparam int PNUM_W       = 17;     // |wsum|*10 up to 66000
    localparam int PLIM_W       = 20;     // total*701
    localparam int QW           = 10;     // quotient bits of the shared divider
    localparam int CNT_W        = 4;
    localparam int SCALE_STEPS  = 7;
    localparam int POS_STEPS    = 10;
    localparam int OUT_TDATA_W  = 16;

    // op codes carried in the input tuser
    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_MEASURE   = 1'b1;

    typedef struct packed {
        logic calib;        // widen min/max from the incoming word
        logic load_meas;    // capture readings, clear sums
        logic acc_direct;   // add a scaled value that needs no division
        logic sc_start;     // load divider for the current sensor
        logic div_step;     // one restoring division step
        logic acc_quot;     // add the divider quotient as scaled value
        logic idx_inc;      // advance to next sensor
        logic pd_start;     // set up the position division or the direct result
        logic pd_finish;    // turn the quotient into the signed position
        logic out_write;    // move the result into the output register
    } lpe_cmd_t;

    typedef struct packed {
        logic sc_direct;
        logic idx_last;
        logic div_done;
        logic pd_direct;
        logic out_free;
    } lpe_sts_t;

    // centroid weights in tenths, left positive
    function automatic logic signed [SCALE_W-1:0] weight_of(input logic [IDX_W-1:0] idx);
        logic signed [SCALE_W-1:0] w;
        case (idx)
            3'd0:    w = 7'sd36;
            3'd1:    w = 7'sd20;
            3'd2:    w = 7'sd10;
            3'd3:    w = 7'sd0;
            3'd4:    w = -7'sd10;
            3'd5:    w = -7'sd20;
            3'd6:    w = -7'sd36;
            default: w = 7'sd0;
        endcase
        return w;
    endfunction

endpackage

// File: src/line_position_estimator_unit.sv
// top level of the line position estimator
//
//  channel   group                 tdata                         tuser
//  -------   -------------------   ---------------------------   ------------------
//  input     s_axis_t{valid,ready}  reading_0..reading_6, ADC_BITS   op (0 calibrate,
//                                   each, sensor 0 lowest            1 measure)
//  output    m_axis_t{valid,ready}  position, 11-bit signed        line_absent
//
//  a calibrate word is absorbed in the cycle it is accepted and gives no result;
//  the block is ready again on the next cycle
//  a measure word passes each sensor through setup, and through the divider and an
//  accumulate step when its scale needs a division, then sets up the position and
//  divides again only when the position needs it; the one-bit-a-cycle restoring
//  divider is shared by up to eight divisions (7 steps per sensor scale, 10 for the centroid)
//  the finished result waits in an output register, so the next word is taken
//  while it is still unread; a stalled output holds only the final hand-off
//  reset (rst_n, asynchronous, active low) sets every minimum to full scale,
//  every maximum and the last position to zero, and empties the output
module line_position_estimator_unit
    import lpe_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // reading_0 .. reading_6 from the lowest bit up, zero padded to bytes
    input  logic [((SENSORS*ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // position in the low 11 bits, upper bits zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // line_absent
    output logic m_axis_tuser
);

    lpe_cmd_t                cmd;
    lpe_sts_t                sts;
    logic signed [POS_W-1:0] position;

    // state machine: accepts words and steps the datapath through the scale,
    // accumulate and centroid phases
    lpe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: calibration registers, shared divider, sums, result register
    lpe_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .readings    (s_axis_tdata[SENSORS*ADC_BITS-1:0]),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .position    (position),
        .line_absent (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-POS_W){1'b0}}, position};

endmodule

// File: src/lpe_ctrl.sv
// sequencing state machine for the line position estimator
module lpe_ctrl
    import lpe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_op,
    output logic     in_ready,
    input  lpe_sts_t sts,
    output lpe_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_SDIV  = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_PSET  = 3'd4;
    localparam logic [2:0] ST_PDIV  = 3'd5;
    localparam logic [2:0] ST_PFIN  = 3'd6;
    localparam logic [2:0] ST_RES   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.calib     = accept && (in_op == OP_CALIBRATE);
                cmd.load_meas = accept && (in_op == OP_MEASURE);
                if (accept && (in_op == OP_MEASURE))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (sts.sc_direct)
                begin
                    cmd.acc_direct = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = ST_PSET;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
                else
                begin
                    cmd.sc_start = 1'b1;
                    state_next   = ST_SDIV;
                end
            end
            ST_SDIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc_quot = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = ST_PSET;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_PSET:
            begin
                cmd.pd_start = 1'b1;
                state_next   = sts.pd_direct ? ST_RES : ST_PDIV;
            end
            ST_PDIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_PFIN;
                end
            end
            ST_PFIN:
            begin
                cmd.pd_finish = 1'b1;
                state_next    = ST_RES;
            end
            ST_RES:
            begin
                if (sts.out_free)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/lpe_dp.sv
// calibration store, shared serial divider, sums and output register
module lpe_dp
    import lpe_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [SENSORS*ADC_BITS-1:0] readings,
    input  lpe_cmd_t                  cmd,
    output lpe_sts_t                  sts,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic signed [POS_W-1:0]   position,
    output logic                      line_absent
);

    localparam int SNUM_W = ADC_BITS + SCALE_W;
    localparam int DW     = (SNUM_W > PLIM_W - 1) ? SNUM_W : PLIM_W - 1;

    logic [ADC_BITS-1:0]        min_reg [SENSORS];
    logic [ADC_BITS-1:0]        max_reg [SENSORS];
    logic [ADC_BITS-1:0]        raw_reg [SENSORS];
    logic [IDX_W-1:0]           idx_reg;
    logic signed [WSUM_W-1:0]   wsum_reg;
    logic [TOTAL_W-1:0]         total_reg;
    logic [DW-1:0]              rem_reg;
    logic [DW-1:0]              dsh_reg;
    logic [QW-1:0]              quot_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       neg_reg;
    logic signed [POS_W-1:0]    res_pos_reg;
    logic                       res_absent_reg;
    logic signed [POS_W-1:0]    last_pos_reg;
    logic                       out_valid_reg;
    logic signed [POS_W-1:0]    out_pos_reg;
    logic                       out_absent_reg;

    logic [ADC_BITS-1:0]        lo;
    logic [ADC_BITS-1:0]        hi;
    logic [ADC_BITS-1:0]        r;
    logic                       flat_or_low;
    logic [SCALE_W-1:0]         direct_val;
    logic [SNUM_W-1:0]          snum;
    logic [SCALE_W-1:0]         s_val;
    logic signed [WSUM_W-1:0]   s_ext;
    logic signed [WSUM_W-1:0]   w_ext;
    logic signed [WSUM_W-1:0]   wprod;
    logic [WSUM_W-1:0]          wmag;
    logic [PNUM_W-1:0]          pnum;
    logic [PLIM_W-1:0]          plim;
    logic                       clamp;
    logic                       rem_ge;
    logic [QW-1:0]              pmag;

    // current sensor operands
    assign lo = min_reg[idx_reg];
    assign hi = max_reg[idx_reg];
    assign r  = raw_reg[idx_reg];

    assign flat_or_low   = (hi <= lo) || (r <= lo);
    assign sts.sc_direct = flat_or_low || (r >= hi);
    assign direct_val    = flat_or_low ? '0 : SCALE_W'(SCALE_FULL);
    assign snum          = SNUM_W'(r - lo) * SNUM_W'(SCALE_FULL);
    assign sts.idx_last  = (idx_reg == IDX_W'(SENSORS - 1));

    // accumulate either the direct value or the quotient
    assign s_val = cmd.acc_direct ? direct_val : quot_reg[SCALE_W-1:0];
    assign s_ext = WSUM_W'(s_val);
    assign w_ext = WSUM_W'(weight_of(idx_reg));
    assign wprod = s_ext * w_ext;

    // position division operands
    assign wmag  = wsum_reg[WSUM_W-1] ? WSUM_W'(-wsum_reg) : WSUM_W'(wsum_reg);
    assign pnum  = PNUM_W'(wmag) * PNUM_W'(10);
    assign plim  = PLIM_W'(total_reg) * PLIM_W'(POS_LIMIT + 1);
    assign clamp = (PLIM_W'(pnum) >= plim);
    assign sts.pd_direct = (total_reg == '0) || clamp;

    // shared restoring divider, one quotient bit a cycle
    assign rem_ge       = (rem_reg >= dsh_reg);
    assign sts.div_done = (cnt_reg == CNT_W'(1));
    assign pmag         = quot_reg;

    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSORS; i++)
            begin
                min_reg[i] <= '1;
                max_reg[i] <= '0;
            end
            last_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.calib)
            begin
                for (int i = 0; i < SENSORS; i++)
                begin
                    if (readings[i*ADC_BITS +: ADC_BITS] > max_reg[i])
                    begin
                        max_reg[i] <= readings[i*ADC_BITS +: ADC_BITS];
                    end
                    if (readings[i*ADC_BITS +: ADC_BITS] < min_reg[i])
                    begin
                        min_reg[i] <= readings[i*ADC_BITS +: ADC_BITS];
                    end
                end
            end
            if (cmd.out_write)
            begin
                out_valid_reg <= 1'b1;
                last_pos_reg  <= res_pos_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_meas)
        begin
            for (int i = 0; i < SENSORS; i++)
            begin
                raw_reg[i] <= readings[i*ADC_BITS +: ADC_BITS];
            end
            idx_reg   <= '0;
            wsum_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.acc_direct || cmd.acc_quot)
            begin
                wsum_reg  <= wsum_reg + wprod;
                total_reg <= total_reg + TOTAL_W'(s_val);
            end
        end

        if (cmd.sc_start)
        begin
            rem_reg  <= DW'(snum);
            dsh_reg  <= DW'(hi - lo) << (SCALE_STEPS - 1);
            quot_reg <= '0;
            cnt_reg  <= CNT_W'(SCALE_STEPS);
        end
        else if (cmd.pd_start)
        begin
            rem_reg  <= DW'(pnum);
            dsh_reg  <= DW'(total_reg) << (POS_STEPS - 1);
            quot_reg <= '0;
            cnt_reg  <= CNT_W'(POS_STEPS);
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[QW-2:0], rem_ge};
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end

        if (cmd.pd_start)
        begin
            neg_reg <= wsum_reg[WSUM_W-1];
            if (total_reg == '0)
            begin
                // line lost: repeat the previous position
                res_pos_reg    <= last_pos_reg;
                res_absent_reg <= 1'b1;
            end
            else
            begin
                res_pos_reg    <= wsum_reg[WSUM_W-1] ? -POS_W'(POS_LIMIT) : POS_W'(POS_LIMIT);
                res_absent_reg <= 1'b0;
            end
        end
        else if (cmd.pd_finish)
        begin
            res_pos_reg <= neg_reg ? -POS_W'(pmag) : POS_W'(pmag);
        end

        if (cmd.out_write)
        begin
            out_pos_reg    <= res_pos_reg;
            out_absent_reg <= res_absent_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = out_pos_reg;
    assign line_absent = out_absent_reg;

endmodule

// File: src/lpe_checker.sv
// port-level checker for the line position estimator, bound to the top level
module lpe_checker
    import lpe_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic [((SENSORS*ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
    input logic s_axis_tuser,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic m_axis_tuser
);

    // a waiting result holds its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // position stays inside the clamp range, padding stays zero
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[POS_W-1:0]) <= $signed(POS_W'(POS_LIMIT)))
            && ($signed(m_axis_tdata[POS_W-1:0]) >= -$signed(POS_W'(POS_LIMIT)))
            && (m_axis_tdata[OUT_TDATA_W-1:POS_W] == '0))
        else $error("position out of range");

    // a calibrate word never produces a result
    a_cal_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_CALIBRATE) && !m_axis_tvalid
            |=> !m_axis_tvalid)
        else $error("result after calibrate word");

    // a measure word keeps the input closed while it is worked on
    a_meas_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_MEASURE) |=> !s_axis_tready)
        else $error("input reopened during measurement");

endmodule

bind line_position_estimator_unit lpe_checker #(.ADC_BITS(ADC_BITS)) u_lpe_checker (.*);
